[sv/epoch_seconds_to_calendar_assert.svh]
// Assertion macros for the epoch seconds to calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// Check a condition at every edge where the antecedent holds.
`define ESC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("esc check failed");

// Check a condition in the cycle after the antecedent holds.
`define ESC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("esc check failed");

`endif

[sv/esc_pkg.sv]
// Shared constants and types for the epoch seconds to calendar converter.
`default_nettype none
package esc_pkg;
    localparam int TIME_BITS = 36;
    localparam int LAT       = 12;

    // Offset that makes every time non-negative; a whole number of 400-year
    // cycles, which is also a whole number of weeks.
    localparam logic [36:0] EPOCH_BIAS = 37'd37868342400;
    // Biased day count to days since 0000-03-01.
    localparam logic [20:0] CIVIL_SHIFT = 21'd281177;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
        logic [2:0] wd;
    } tod_t;
endpackage
`default_nettype wire

[sv/esc_day_split.sv]
// Seconds to biased day count, second of day and weekday, three stages.
`default_nettype none
module esc_day_split (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic signed [35:0]   epoch,
    output logic [20:0]               z,
    output logic [16:0]               sod,
    output logic [2:0]                wd
);
    import esc_pkg::*;

    localparam longint unsigned M675L = ((64'd1 << 40) + 64'd674) / 64'd675;
    localparam logic [30:0] M675 = 31'(M675L);

    logic [29:0] s1_q_reg;
    logic [6:0]  s1_r_reg;
    logic [29:0] s2_q_reg;
    logic [6:0]  s2_r_reg;
    logic [19:0] s2_days_reg;
    logic [20:0] s3_z_reg;
    logic [16:0] s3_sod_reg;
    logic [2:0]  s3_wd_reg;

    logic [36:0] s1_u_next;
    logic [60:0] prod;
    logic [19:0] s2_days_next;
    logic [29:0] rem;
    logic [20:0] w;
    logic [5:0]  dsum;
    logic [3:0]  dsum2;
    logic [2:0]  s3_wd_next;

    always_comb begin
        s1_u_next    = {epoch[35], epoch} + EPOCH_BIAS;
        prod         = 61'(s1_q_reg) * 61'(M675);
        s2_days_next = prod[59:40];
        rem          = s2_q_reg - 30'(s2_days_reg) * 30'd675;
        w            = 21'(s2_days_reg) + 21'd4;
        dsum         = '0;
        for (int i = 0; i < 7; i++) begin
            dsum = dsum + 6'(w[3*i +: 3]);
        end
        dsum2      = 4'(dsum[2:0]) + 4'(dsum[5:3]);
        s3_wd_next = (dsum2 >= 4'd7) ? 3'(dsum2 - 4'd7) : dsum2[2:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_q_reg    <= s1_u_next[36:7];
            s1_r_reg    <= s1_u_next[6:0];
            s2_q_reg    <= s1_q_reg;
            s2_r_reg    <= s1_r_reg;
            s2_days_reg <= s2_days_next;
            s3_z_reg    <= 21'(s2_days_reg) + CIVIL_SHIFT;
            s3_sod_reg  <= {rem[9:0], s2_r_reg};
            s3_wd_reg   <= s3_wd_next;
        end
    end

    assign z   = s3_z_reg;
    assign sod = s3_sod_reg;
    assign wd  = s3_wd_reg;
endmodule
`default_nettype wire

[sv/esc_clock.sv]
// Second of day to hour, minute, second; weekday delayed alongside.
`default_nettype none
module esc_clock (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire logic [16:0]    sod,
    input  wire logic [2:0]     wd,
    output esc_pkg::tod_t       tod
);
    import esc_pkg::*;

    localparam logic [17:0] M60A = 18'(((32'd1 << 23) + 32'd59) / 32'd60);
    localparam logic [11:0] M60B = 12'(((32'd1 << 17) + 32'd59) / 32'd60);

    logic [16:0] k1_sod_reg;
    logic [10:0] k1_mt_reg;
    logic [2:0]  k1_wd_reg;
    logic [5:0]  k2_sec_reg;
    logic [10:0] k2_mt_reg;
    logic [4:0]  k2_hr_reg;
    logic [2:0]  k2_wd_reg;
    tod_t        dly_reg [7];

    logic [34:0] p1;
    logic [22:0] p2;
    logic [16:0] sec_full;
    logic [10:0] min_full;
    tod_t        k3_next;

    always_comb begin
        p1       = 35'(sod) * 35'(M60A);
        p2       = 23'(k1_mt_reg) * 23'(M60B);
        sec_full = k1_sod_reg - 17'(k1_mt_reg) * 17'd60;
        min_full = k2_mt_reg - 11'(k2_hr_reg) * 11'd60;
        k3_next.sec = k2_sec_reg;
        k3_next.min = min_full[5:0];
        k3_next.hr  = k2_hr_reg;
        k3_next.wd  = k2_wd_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k1_sod_reg <= sod;
            k1_mt_reg  <= p1[33:23];
            k1_wd_reg  <= wd;
            k2_sec_reg <= sec_full[5:0];
            k2_mt_reg  <= k1_mt_reg;
            k2_hr_reg  <= p2[21:17];
            k2_wd_reg  <= k1_wd_reg;
            dly_reg[0] <= k3_next;
            for (int i = 1; i < 7; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign tod = dly_reg[6];
endmodule
`default_nettype wire

[sv/esc_civil.sv]
// Day count since 0000-03-01 to year, month, day of month, day of year; nine stages.
`default_nettype none
module esc_civil (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire logic [20:0]    z,
    output logic signed [11:0]  year,
    output logic [8:0]          doy,
    output logic [3:0]          mon,
    output logic [4:0]          dom
);
    import esc_pkg::*;

    localparam logic [18:0] M1460 = 19'(((32'd1 << 29) + 32'd1459) / 32'd1460);
    localparam logic [18:0] M365  = 19'(((32'd1 << 27) + 32'd364) / 32'd365);
    localparam logic [11:0] M153  = 12'(((32'd1 << 19) + 32'd152) / 32'd153);
    localparam logic [11:0] M5    = 12'(((32'd1 << 14) + 32'd4) / 32'd5);

    logic [2:0]  c1_era_reg, c2_era_reg, c3_era_reg, c4_era_reg, c5_era_reg;
    logic [2:0]  c6_era_reg, c7_era_reg;
    logic [17:0] c1_doe_reg, c2_doe_reg, c3_doe_reg, c4_doe_reg;
    logic [6:0]  c2_q_reg;
    logic [17:0] c3_x_reg;
    logic [8:0]  c4_yoe_reg, c5_yoe_reg, c6_yoe_reg, c7_yoe_reg;
    logic [8:0]  c5_doy_reg, c6_doy_reg, c7_doy_reg, c8_doy_reg;
    logic [10:0] c6_n_reg;
    logic [3:0]  c7_mp_reg;
    logic [10:0] c8_n2_reg;
    logic [11:0] c8_year_reg, c9_year_reg;
    logic [8:0]  c8_doyj_reg, c9_doyj_reg;
    logic [3:0]  c8_mon_reg, c9_mon_reg;
    logic [4:0]  c9_dom_reg;

    logic [2:0]  c1_era_next;
    logic [20:0] doe_full;
    logic [36:0] pq;
    logic [2:0]  cnt_c;
    logic [17:0] c3_x_next;
    logic [36:0] py;
    logic [1:0]  q100;
    logic [17:0] base;
    logic [17:0] doy_full;
    logic [22:0] pm;
    logic        carry;
    logic [8:0]  yy;
    logic        leap;
    logic [12:0] yfull;
    logic [22:0] pd;
    logic [8:0]  dom_full;

    always_comb begin
        c1_era_next = '0;
        for (int k = 1; k < 8; k++) begin
            if (z >= 21'(k * 146097)) begin
                c1_era_next = 3'(k);
            end
        end
        doe_full = z - 21'(c1_era_next) * 21'd146097;

        pq = 37'(c1_doe_reg) * 37'(M1460);

        cnt_c = 3'(c2_doe_reg >= 18'd36524) + 3'(c2_doe_reg >= 18'd73048)
              + 3'(c2_doe_reg >= 18'd109572) + 3'(c2_doe_reg >= 18'd146096);
        c3_x_next = c2_doe_reg - 18'(c2_q_reg) + 18'(cnt_c)
                  - 18'(c2_doe_reg == 18'd146096);

        py = 37'(c3_x_reg) * 37'(M365);

        q100 = 2'(c4_yoe_reg >= 9'd100) + 2'(c4_yoe_reg >= 9'd200)
             + 2'(c4_yoe_reg >= 9'd300);
        base = 18'(c4_yoe_reg) * 18'd365 + 18'(c4_yoe_reg[8:2]) - 18'(q100);
        doy_full = c4_doe_reg - base;

        pm = 23'(c6_n_reg) * 23'(M153);

        carry = (c7_mp_reg >= 4'd10);
        yy    = c7_yoe_reg + 9'(carry);
        leap  = (yy[1:0] == 2'd0) && (yy != 9'd100) && (yy != 9'd200) && (yy != 9'd300);
        yfull = 13'(c7_era_reg) * 13'd400 + 13'(yy) - 13'd1900;

        pd = 23'(c8_n2_reg) * 23'(M5);
        dom_full = c8_doy_reg - pd[22:14] + 9'd1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_era_reg  <= c1_era_next;
            c1_doe_reg  <= doe_full[17:0];
            c2_era_reg  <= c1_era_reg;
            c2_doe_reg  <= c1_doe_reg;
            c2_q_reg    <= pq[35:29];
            c3_era_reg  <= c2_era_reg;
            c3_doe_reg  <= c2_doe_reg;
            c3_x_reg    <= c3_x_next;
            c4_era_reg  <= c3_era_reg;
            c4_doe_reg  <= c3_doe_reg;
            c4_yoe_reg  <= py[35:27];
            c5_era_reg  <= c4_era_reg;
            c5_yoe_reg  <= c4_yoe_reg;
            c5_doy_reg  <= doy_full[8:0];
            c6_era_reg  <= c5_era_reg;
            c6_yoe_reg  <= c5_yoe_reg;
            c6_doy_reg  <= c5_doy_reg;
            c6_n_reg    <= 11'(c5_doy_reg) * 11'd5 + 11'd2;
            c7_era_reg  <= c6_era_reg;
            c7_yoe_reg  <= c6_yoe_reg;
            c7_doy_reg  <= c6_doy_reg;
            c7_mp_reg   <= pm[22:19];
            c8_doy_reg  <= c7_doy_reg;
            c8_n2_reg   <= 11'(c7_mp_reg) * 11'd153 + 11'd2;
            c8_year_reg <= yfull[11:0];
            c8_mon_reg  <= carry ? c7_mp_reg - 4'd10 : c7_mp_reg + 4'd2;
            c8_doyj_reg <= carry ? c7_doy_reg - 9'd306
                                 : c7_doy_reg + 9'd59 + 9'(leap);
            c9_year_reg <= c8_year_reg;
            c9_mon_reg  <= c8_mon_reg;
            c9_doyj_reg <= c8_doyj_reg;
            c9_dom_reg  <= dom_full[4:0];
        end
    end

    assign year = signed'(c9_year_reg);
    assign doy  = c9_doyj_reg;
    assign mon  = c9_mon_reg;
    assign dom  = c9_dom_reg;
endmodule
`default_nettype wire

[sv/epoch_seconds_to_calendar.sv]
// Top level of the epoch seconds to calendar converter.
// Converts signed seconds since 1970-01-01 UTC into Gregorian calendar fields.
// Fully pipelined: one word enters per cycle while the output is not stalled,
// through 12 register stages (3 for day and second-of-day split, 9 for the date
// and clock fields). When m_ready is low with a result waiting, the whole pipeline
// holds and s_ready drops.
`default_nettype none
module epoch_seconds_to_calendar (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [35:0] s_epoch_seconds,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [5:0]              m_second_of_minute,
    output logic [5:0]              m_minute_of_hour,
    output logic [4:0]              m_hour_of_day,
    output logic [2:0]              m_weekday,
    output logic signed [11:0]      m_years_since_1900,
    output logic [8:0]              m_day_of_year,
    output logic [3:0]              m_month_index,
    output logic [4:0]              m_day_of_month
);
    import esc_pkg::*;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           en;
    logic [20:0]    z;
    logic [16:0]    sod;
    logic [2:0]     wd;
    tod_t           tod;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    esc_day_split u_split (
        .aclk  (aclk),
        .en    (en),
        .epoch (s_epoch_seconds),
        .z     (z),
        .sod   (sod),
        .wd    (wd)
    );

    esc_clock u_clock (
        .aclk (aclk),
        .en   (en),
        .sod  (sod),
        .wd   (wd),
        .tod  (tod)
    );

    esc_civil u_civil (
        .aclk (aclk),
        .en   (en),
        .z    (z),
        .year (m_years_since_1900),
        .doy  (m_day_of_year),
        .mon  (m_month_index),
        .dom  (m_day_of_month)
    );

    assign m_second_of_minute = tod.sec;
    assign m_minute_of_hour   = tod.min;
    assign m_hour_of_day      = tod.hr;
    assign m_weekday          = tod.wd;

`include "epoch_seconds_to_calendar_assert.svh"

    `ESC_ASSERT_NOW(a_field_range, m_valid, (m_hour_of_day < 5'd24) && (m_minute_of_hour < 6'd60) && (m_second_of_minute < 6'd60) && (m_weekday < 3'd7) && (m_month_index < 4'd12) && (m_day_of_month != 5'd0))
    `ESC_ASSERT_NOW(a_jan_doy, m_valid && (m_month_index == 4'd0), m_day_of_year == 9'(m_day_of_month) - 9'd1)
    `ESC_ASSERT_NOW(a_feb_doy, m_valid && (m_month_index == 4'd1), m_day_of_year == 9'(m_day_of_month) + 9'd30)
    `ESC_ASSERT_NEXT(a_stall_freeze, m_valid && !m_ready, $stable(vld_reg))
endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench for the epoch seconds to calendar converter, checked against a built-in predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [5:0]         sec;
        logic [5:0]         min;
        logic [4:0]         hr;
        logic [2:0]         wd;
        logic signed [11:0] yr;
        logic [8:0]         yday;
        logic [3:0]         mon;
        logic [4:0]         mday;
    } cal_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [35:0]      s_epoch_seconds = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [5:0]              m_second_of_minute;
    logic [5:0]              m_minute_of_hour;
    logic [4:0]              m_hour_of_day;
    logic [2:0]              m_weekday;
    logic signed [11:0]      m_years_since_1900;
    logic [8:0]              m_day_of_year;
    logic [3:0]              m_month_index;
    logic [4:0]              m_day_of_month;

    logic signed [35:0] pending_times[$];
    cal_t               expected_dates[$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    int                 send_gap = 0;
    int                 recv_gap = 0;
    bit                 stimulus_done = 0;

    epoch_seconds_to_calendar uut (.*);

    always #5 aclk = ~aclk;

    function automatic bit is_leap(longint y);
        return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    function automatic longint floor_mod(longint a, longint b);
        longint r;
        r = a % b;
        if (r < 0) r += b;
        return r;
    endfunction

    function automatic cal_t to_calendar(logic signed [35:0] t_in);
        longint t, sod, days, wd, cycles, dyear, year, d, ml, ylen;
        int     m;
        cal_t   c;
        int     mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        t = t_in;
        sod = floor_mod(t, 86400);
        days = (t - sod) / 86400;
        wd = floor_mod(days + 4, 7);
        dyear = floor_mod(days, 146097);
        cycles = (days - dyear) / 146097;
        year = 1970 + 400 * cycles;
        ylen = is_leap(year) ? 366 : 365;
        while (dyear >= ylen) begin
            dyear -= ylen;
            year++;
            ylen = is_leap(year) ? 366 : 365;
        end
        d = dyear;
        m = 0;
        while (m < 11) begin
            ml = (m == 1 && is_leap(year)) ? 29 : mlen[m];
            if (d < ml) break;
            d -= ml;
            m++;
        end
        c.sec = 6'(sod % 60);
        c.min = 6'((sod / 60) % 60);
        c.hr = 5'(sod / 3600);
        c.wd = 3'(wd);
        c.yr = 12'(year - 1900);
        c.yday = 9'(dyear);
        c.mon = 4'(m);
        c.mday = 5'(d + 1);
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic signed [35:0] date_time(int year, int yday, int sod);
        longint days, y;
        days = 0;
        for (y = 1970; y < year; y++) days += is_leap(y) ? 366 : 365;
        for (y = year; y < 1970; y++) days -= is_leap(y) ? 366 : 365;
        return 36'((days + yday) * 86400 + sod);
    endfunction

    initial begin
        logic signed [35:0] v;
        int yr;
        pending_times.push_back(36'sd0);
        pending_times.push_back(-36'sd1);
        pending_times.push_back(36'sd86399);
        pending_times.push_back(36'sd86400);
        pending_times.push_back(-36'sd86400);
        pending_times.push_back(-36'sd86401);
        pending_times.push_back({1'b0, {35{1'b1}}});
        pending_times.push_back({1'b1, {35{1'b0}}});
        pending_times.push_back({1'b1, {34{1'b0}}, 1'b1});
        pending_times.push_back({1'b0, {34{1'b1}}, 1'b0});
        pending_times.push_back(36'sd951782400);
        pending_times.push_back(36'sd951868799);
        pending_times.push_back(36'sd4107542400);
        pending_times.push_back(36'sd978307199);
        pending_times.push_back(-36'sd2208988800);
        pending_times.push_back(-36'sd11676096000);
        pending_times.push_back(36'sd2147483647);
        pending_times.push_back(36'sd2147483648);
        pending_times.push_back(36'h555555555);
        pending_times.push_back(36'hAAAAAAAAA);
        pending_times.push_back(date_time(2000, 365, 86399));
        pending_times.push_back(date_time(1900, 59, 0));
        for (int i = 0; i < 500; i++) begin
            case ($urandom_range(0, 3))
                0: v = 36'({$urandom(), $urandom()});
                1: v = 36'($signed($urandom()));
                2: begin
                    yr = $urandom_range(900, 3000);
                    v = date_time(yr, $urandom_range(0, is_leap(yr) ? 365 : 364),
                                  $urandom_range(0, 86399));
                end
                default: begin
                    yr = 4 * $urandom_range(230, 750);
                    v = date_time(yr, $urandom_range(58, 60), $urandom_range(0, 86399));
                end
            endcase
            pending_times.push_back(v);
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // drive input words
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_dates.push_back(to_calendar(s_epoch_seconds));
                send_gap = pick_gap();
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_times.size() > 0) begin
                    s_valid <= 1'b1;
                    s_epoch_seconds <= pending_times.pop_front();
                end else begin
                    s_valid <= 1'b0;
                    stimulus_done = 1;
                end
            end
        end
    end

    // check result words
    always @(posedge aclk) begin
        cal_t got, exp_c;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_second_of_minute, m_minute_of_hour, m_hour_of_day, m_weekday,
                        m_years_since_1900, m_day_of_year, m_month_index, m_day_of_month};
                if (expected_dates.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %p", got);
                end else begin
                    exp_c = expected_dates.pop_front();
                    if (got !== exp_c) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch exp %p got %p", exp_c, got);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (stimulus_done && expected_dates.size() == 0);
        fork
            repeat (50) @(posedge aclk);
            wait (idle_cycles >= WATCHDOG_LIMIT);
        join_any
        if (mismatches == 0 && idle_cycles < WATCHDOG_LIMIT) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end
endmodule
